>>> hw/rtl/memory_lcd_frame_controller_defines.svh
// Assertion macros shared by the memory LCD frame controller RTL.
// Needs a clk and an active-high rst in the scope where a macro is used.
`ifndef MEMORY_LCD_FRAME_CONTROLLER_DEFINES_SVH
`define MEMORY_LCD_FRAME_CONTROLLER_DEFINES_SVH

// Same-cycle implication, muted during reset.
`define MLCD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, muted during reset.
`define MLCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/mlcd_pkg.sv
// Shared types and constants of the memory LCD frame controller.
// No dependencies.
package mlcd_pkg;

  // Input modes
  localparam logic [1:0] MODE_DRAW    = 2'd0;
  localparam logic [1:0] MODE_FILL    = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;
  localparam logic [1:0] MODE_REFRESH = 2'd3;

  // Panel command bytes
  localparam logic [7:0] CMD_WRITE = 8'h80;
  localparam logic [7:0] CMD_CLEAR = 8'h20;

  // Byte group index of an 8-bit pixel position (pixel / 8)
  localparam int GW = 5;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SWEEP,
    DP_RMW_RD,
    DP_RMW_WR,
    DP_REF_RD,
    DP_REF_EMIT,
    DP_CLR_CMD,
    DP_CLR_END
  } dp_op_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic sweep_last;  // sweep pointer at the last store entry
    logic rect_empty;  // incoming draw/fill hits no pixel after clipping
    logic rect_last;   // current fill byte is the final one
    logic out_free;    // output register can take a beat this cycle
  } dp_status_t;

endpackage

>>> hw/rtl/mlcd_ctrl.sv
// Controller state machine of the memory LCD frame controller.
// Depends on mlcd_pkg; drives datapath operations, reads datapath status.
module mlcd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          mode,
  input  mlcd_pkg::dp_status_t status,
  output mlcd_pkg::dp_op_t    op
);
  import mlcd_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RMW_RD,
    S_RMW_WR,
    S_REF_RD,
    S_REF_EMIT,
    S_CLR_SWEEP,
    S_CLR_CMD,
    S_CLR_END
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op         = DP_NOP;
    case (state)
      S_INIT: begin
        op = DP_SWEEP;
        if (status.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op = DP_LOAD;
          case (mode)
            MODE_DRAW, MODE_FILL: state_next = status.rect_empty ? S_IDLE : S_RMW_RD;
            MODE_CLEAR:           state_next = S_CLR_SWEEP;
            default:              state_next = S_REF_RD;
          endcase
        end
      end
      S_RMW_RD: begin
        op         = DP_RMW_RD;
        state_next = S_RMW_WR;
      end
      S_RMW_WR: begin
        op         = DP_RMW_WR;
        state_next = status.rect_last ? S_IDLE : S_RMW_RD;
      end
      S_REF_RD: begin
        op         = DP_REF_RD;
        state_next = S_REF_EMIT;
      end
      S_REF_EMIT: begin
        if (status.out_free) begin
          op         = DP_REF_EMIT;
          state_next = S_IDLE;
        end
      end
      S_CLR_SWEEP: begin
        op = DP_SWEEP;
        if (status.sweep_last) state_next = S_CLR_CMD;
      end
      S_CLR_CMD: begin
        if (status.out_free) begin
          op         = DP_CLR_CMD;
          state_next = S_CLR_END;
        end
      end
      S_CLR_END: begin
        if (status.out_free) begin
          op         = DP_CLR_END;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/mlcd_dp.sv
// Datapath of the memory LCD frame controller: frame store, fill walker,
// write-frame sequencer and output register. Depends on mlcd_pkg and the defines header.
`include "memory_lcd_frame_controller_defines.svh"

module mlcd_dp #(
  parameter int LINES          = 128,
  parameter int BYTES_PER_LINE = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mlcd_pkg::dp_op_t     op,
  output mlcd_pkg::dp_status_t status,
  input  logic [1:0]           mode,
  input  logic [7:0]           line_a,
  input  logic [7:0]           pixel_a,
  input  logic [7:0]           line_b,
  input  logic [7:0]           pixel_b,
  input  logic                 draw,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           tx_byte,
  output logic                 end_of_transfer,
  output logic                 last
);
  import mlcd_pkg::*;

  localparam int DEPTH   = LINES * BYTES_PER_LINE;
  localparam int AW      = $clog2(DEPTH);
  localparam int LAW     = $clog2(LINES);
  localparam int GTW     = $clog2(LINES + 1);
  localparam int BW      = (BYTES_PER_LINE > 1) ? $clog2(BYTES_PER_LINE) : 1;
  localparam int PIX_CNT = 8 * BYTES_PER_LINE;

  typedef enum logic [2:0] {
    PH_CMD,
    PH_ADDR,
    PH_DATA,
    PH_TRAIL,
    PH_END0,
    PH_END1
  } ref_phase_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7 - i];
    return r;
  endfunction

  // ---------------- frame store ----------------
  logic [7:0]    mem [DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  // ---------------- clearing sweep ----------------
  logic [AW-1:0] sweep_addr;

  always_ff @(posedge clk) begin
    if (rst || op == DP_LOAD) begin
      sweep_addr <= '0;
    end else if (op == DP_SWEEP) begin
      sweep_addr <= sweep_addr + 1'b1;
    end
  end

  // ---------------- fill / draw walker ----------------
  logic [7:0]     l_lo, l_hi, p_lo, p_hi, p_end;
  logic [LAW-1:0] l_end;
  logic           rect_empty;
  logic           is_fill;

  always_comb begin
    is_fill    = (mode == MODE_FILL);
    l_lo       = (is_fill && line_b  < line_a)  ? line_b  : line_a;
    l_hi       = (is_fill && line_b  > line_a)  ? line_b  : line_a;
    p_lo       = (is_fill && pixel_b < pixel_a) ? pixel_b : pixel_a;
    p_hi       = (is_fill && pixel_b > pixel_a) ? pixel_b : pixel_a;
    rect_empty = (32'(l_lo) >= LINES) || (32'(p_lo) >= PIX_CNT);
    l_end      = (32'(l_hi) >= LINES) ? LAW'(LINES - 1) : LAW'(l_hi);
    p_end      = (32'(p_hi) >= PIX_CNT) ? 8'(PIX_CNT - 1) : p_hi;
  end

  logic [LAW-1:0] cur_line, end_line;
  logic [GW-1:0]  g, g0, g1;
  logic [2:0]     lo0, hi1;
  logic [AW-1:0]  base;
  logic           fill_on;
  logic [AW-1:0]  fill_addr;
  logic [7:0]     fill_mask, fill_data;
  logic           group_last, rect_last;

  always_comb begin
    logic [2:0] lo, hi;
    fill_addr  = base + AW'(BYTES_PER_LINE - 1) - AW'(g);
    lo         = (g == g0) ? lo0 : 3'd0;
    hi         = (g == g1) ? hi1 : 3'd7;
    for (int i = 0; i < 8; i++) fill_mask[i] = (3'(i) >= lo) && (3'(i) <= hi);
    fill_data  = fill_on ? (rd_data | fill_mask) : (rd_data & ~fill_mask);
    group_last = (g == g1);
    rect_last  = group_last && (cur_line == end_line);
  end

  always_ff @(posedge clk) begin
    if (op == DP_LOAD) begin
      cur_line <= LAW'(l_lo);
      end_line <= l_end;
      g0       <= p_lo[7:3];
      g1       <= p_end[7:3];
      g        <= p_lo[7:3];
      lo0      <= p_lo[2:0];
      hi1      <= p_end[2:0];
      base     <= AW'(32'(l_lo) * BYTES_PER_LINE);
      fill_on  <= draw;
    end else if (op == DP_RMW_WR) begin
      if (group_last) begin
        g        <= g0;
        cur_line <= cur_line + 1'b1;
        base     <= base + AW'(BYTES_PER_LINE);
      end else begin
        g <= g + 1'b1;
      end
    end
  end

  // ---------------- write-frame sequencer ----------------
  ref_phase_t     phase;
  logic [GTW-1:0] gate;      // 1-based gate line address
  logic [BW-1:0]  col;
  logic [AW-1:0]  ref_addr;

  always_ff @(posedge clk) begin
    if (rst || (op == DP_LOAD && mode == MODE_CLEAR)) begin
      phase    <= PH_CMD;
      gate     <= GTW'(1);
      col      <= '0;
      ref_addr <= '0;
    end else if (op == DP_REF_EMIT) begin
      case (phase)
        PH_CMD: begin
          phase    <= PH_ADDR;
          gate     <= GTW'(1);
          col      <= '0;
          ref_addr <= '0;
        end
        PH_ADDR: phase <= PH_DATA;
        PH_DATA: begin
          ref_addr <= ref_addr + 1'b1;
          if (col == BW'(BYTES_PER_LINE - 1)) begin
            col   <= '0;
            phase <= PH_TRAIL;
          end else begin
            col <= col + 1'b1;
          end
        end
        PH_TRAIL: begin
          if (gate == GTW'(LINES)) begin
            phase <= PH_END0;
          end else begin
            gate  <= gate + 1'b1;
            phase <= PH_ADDR;
          end
        end
        PH_END0: phase <= PH_END1;
        default: phase <= PH_CMD;
      endcase
    end
  end

  logic [7:0] ref_byte;
  logic       ref_eot;

  always_comb begin
    ref_byte = 8'h00;
    ref_eot  = 1'b0;
    case (phase)
      PH_CMD:  ref_byte = CMD_WRITE;
      PH_ADDR: ref_byte = rev8(8'(gate));
      PH_DATA: ref_byte = rd_data;
      PH_END1: ref_eot  = 1'b1;
      default: ref_byte = 8'h00;
    endcase
  end

  // ---------------- memory port muxing ----------------
  always_comb begin
    mem_we    = (op == DP_SWEEP) || (op == DP_RMW_WR);
    mem_waddr = (op == DP_SWEEP) ? sweep_addr : fill_addr;
    mem_wdata = (op == DP_SWEEP) ? 8'h00 : fill_data;
    mem_re    = (op == DP_RMW_RD) || (op == DP_REF_RD);
    mem_raddr = (op == DP_RMW_RD) ? fill_addr : ref_addr;
  end

  // ---------------- output register ----------------
  logic out_load;

  assign out_load = (op == DP_REF_EMIT) || (op == DP_CLR_CMD) || (op == DP_CLR_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      DP_REF_EMIT: begin
        tx_byte         <= ref_byte;
        end_of_transfer <= ref_eot;
        last            <= 1'b1;
      end
      DP_CLR_CMD: begin
        tx_byte         <= CMD_CLEAR;
        end_of_transfer <= 1'b0;
        last            <= 1'b0;
      end
      DP_CLR_END: begin
        tx_byte         <= 8'h00;
        end_of_transfer <= 1'b1;
        last            <= 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------- status ----------------
  always_comb begin
    status.sweep_last = (sweep_addr == AW'(DEPTH - 1));
    status.rect_empty = rect_empty;
    status.rect_last  = rect_last;
    status.out_free   = !out_valid || !out_stall;
  end

  // ---------------- checks ----------------
  `MLCD_ASSERT_IMPL(a_load_when_free, (out_load), (!out_valid || !out_stall), "beat overwritten")
  `MLCD_ASSERT_IMPL(a_group_in_span, (op == DP_RMW_WR), (g >= g0 && g <= g1), "fill group out of span")
  `MLCD_ASSERT_IMPL(a_eot_is_last, (out_valid && end_of_transfer), (last), "eot without last")
  `MLCD_ASSERT_IMPL(a_gate_range, (phase == PH_ADDR), (gate != '0 && gate <= GTW'(LINES)), "gate out of range")
  `MLCD_ASSERT_NEXT(a_frame_wraps, (op == DP_REF_EMIT && phase == PH_END1), (phase == PH_CMD), "frame did not wrap")

endmodule

>>> hw/rtl/memory_lcd_frame_controller.sv
// Top level of the memory LCD frame controller.
// Depends on mlcd_pkg, mlcd_ctrl and mlcd_dp.
//
// Keeps a LINES x BYTES_PER_LINE frame store (one bit per pixel, pixel p of a
// line in byte BYTES_PER_LINE-1-p/8, bit p%8) and turns it into the byte stream
// of a memory LCD. One input beat at a time is worked on; the input stalls
// until the item is done. A draw writes one pixel by a store read, then a
// write of one byte; a fill does one read-modify-write for each byte the
// clipped rectangle touches, over the single store port; a draw or fill that
// lies fully off screen does no store work; a refresh step does a store read,
// then an output load; a clear runs the sweep, writing one store byte per
// cycle, then loads the 0x20 and 0x00 beats. After reset the same sweep
// clears all LINES*BYTES_PER_LINE store bytes (2048 at the default size) with
// the input stalled. Result beats leave through one output register, so a
// new item is taken while a beat still waits on out_stall; a step that must
// emit waits only if that register is still full. Each refresh step returns
// the next byte of the write frame (0x80, then per line the bit-reversed
// 1-based gate address, the line bytes and 0x00, then 0x00 0x00 with
// end_of_transfer); drawing between steps shows in the later bytes, and a
// clear restarts the frame. VCOM stays 0.
module memory_lcd_frame_controller #(
  parameter int LINES          = 128,
  parameter int BYTES_PER_LINE = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] line_a,
  input  logic [7:0] pixel_a,
  input  logic [7:0] line_b,
  input  logic [7:0] pixel_b,
  input  logic       draw,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       end_of_transfer,
  output logic       last
);
  import mlcd_pkg::*;

  dp_op_t     op;      // operation for the datapath this cycle
  dp_status_t status;  // sweep / fill / output flags back to the controller

  mlcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .status   (status),
    .op       (op)
  );

  mlcd_dp #(
    .LINES          (LINES),
    .BYTES_PER_LINE (BYTES_PER_LINE)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .status          (status),
    .mode            (mode),
    .line_a          (line_a),
    .pixel_a         (pixel_a),
    .line_b          (line_b),
    .pixel_b         (pixel_b),
    .draw            (draw),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .tx_byte         (tx_byte),
    .end_of_transfer (end_of_transfer),
    .last            (last)
  );

endmodule
